// File: src/crbu_pkg.sv
// ----------------------------------------------------------------------------
// crbu_pkg: shared types and constants of the bicubic upscaler
// Opcodes, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package crbu_pkg;

  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;
  localparam int DefSampleBits = 32;
  localparam int MaxFactor    = 16;

  // configuration register widths and indexes
  localparam int CfgAddrBits = 2;
  localparam int CfgDataBits = 39;
  localparam int DimBits     = 7;
  localparam int FactorBits  = 5;
  localparam int LimitBits   = 39;

  localparam logic [CfgAddrBits-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CfgAddrBits-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CfgAddrBits-1:0] CFG_FACTOR     = 2'd2;
  localparam logic [CfgAddrBits-1:0] CFG_LIMIT      = 2'd3;

  localparam logic [DimBits-1:0]    RST_SRC_WIDTH  = 7'd64;
  localparam logic [DimBits-1:0]    RST_SRC_HEIGHT = 7'd64;
  localparam logic [FactorBits-1:0] RST_FACTOR     = 5'd10;
  localparam logic [LimitBits-1:0]  RST_LIMIT      = 39'd4096000000;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // port field widths
  localparam int SrcIdxBits  = 6;
  localparam int DestIdxBits = 10;
  localparam int PixelBits   = 40;

  // position divider: |2i-R| in Q16 over 2R
  localparam int WholeBits = DestIdxBits + 1;
  localparam int DivNBits  = WholeBits + 16;
  localparam int DivDBits  = FactorBits + 1;

  // kernel argument (Q16, three integer bits) and weight (Q16)
  typedef logic signed [18:0] arg_t;
  typedef logic signed [17:0] weight_t;

endpackage

`default_nettype wire

// File: src/crbu_ram.sv
// ----------------------------------------------------------------------------
// crbu_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crbu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/crbu_div.sv
// ----------------------------------------------------------------------------
// crbu_div: restoring serial divider
// One quotient bit per cycle; done pulses after NB steps, quotient holds.
// ----------------------------------------------------------------------------
`default_nettype none

module crbu_div #(
  parameter int NB = 27,
  parameter int DB = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NB-1:0] dividend_i,
  input  wire logic [DB-1:0] divisor_i,
  output logic               done_o,
  output logic      [NB-1:0] quotient_o
);

  localparam int CW = $clog2(NB + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DB-1:0] rem_q;
  logic [NB-1:0] quo_q;
  logic [DB-1:0] den_q;
  logic [DB:0]   rem_sh;
  logic [DB:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[NB-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DB-1:0] : rem_sh[DB-1:0];
      quo_q <= {quo_q[NB-2:0], ge};
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: src/crbu_kernel.sv
// ----------------------------------------------------------------------------
// crbu_kernel: pipelined Catmull-Rom weight unit
// Takes a Q16 argument and returns the Q16 weight from its last pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crbu_kernel (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire crbu_pkg::arg_t   arg_i,
  output logic                  out_valid_o,
  output crbu_pkg::weight_t     weight_o
);

  import crbu_pkg::*;

  logic [5:0] v_q;

  // stage 1
  logic [18:0] tabs;
  logic        zero1_q, far1_q;
  logic [16:0] f1_q;
  logic [33:0] f2_1_q;
  // stage 2
  logic        zero2_q, far2_q;
  logic [16:0] f2s_q;
  logic [33:0] f2_2_q;
  logic [50:0] f3_2_q;
  // stage 3
  logic               zero3_q;
  logic signed [63:0] num_d, num_q;
  logic signed [63:0] f3e, f2e, f1e;
  // stage 4
  logic        zero4_q, neg4_q;
  logic [18:0] mag4_q;
  logic [63:0] nabs;
  // stage 5
  logic        zero5_q, neg5_q;
  logic [18:0] mag5_q;
  logic [17:0] est5_q;
  logic [35:0] est_prod;
  // stage 6
  logic [20:0] est6;
  logic [17:0] quo;

  assign tabs     = arg_i[18] ? 19'(-arg_i) : arg_i;
  assign f3e      = $signed({13'b0, f3_2_q});
  assign f2e      = $signed({14'b0, f2_2_q, 16'b0});
  assign f1e      = $signed({15'b0, f2s_q, 32'b0});
  assign nabs     = num_q[63] ? 64'(-num_q) : num_q;
  assign est_prod = mag4_q * 17'd43691;
  assign est6     = {1'b0, est5_q, 2'b0} + {2'b0, est5_q, 1'b0};
  // reciprocal estimate is at most one high
  assign quo      = (est6 > {2'b0, mag5_q}) ? est5_q - 1'b1 : est5_q;

  always_comb begin
    if (!far2_q) begin
      num_d = 64'sd9 * f3e - 64'sd15 * f2e + 64'sh0006_0000_0000_0000;
    end else begin
      num_d = 64'sd15 * f2e - 64'sd3 * f3e - 64'sd24 * f1e + 64'sh000C_0000_0000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      v_q         <= {v_q[4:0], in_valid_i};
      out_valid_o <= v_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    zero1_q <= tabs[17];
    far1_q  <= tabs[16];
    f1_q    <= tabs[16:0];
    f2_1_q  <= tabs[16:0] * tabs[16:0];

    zero2_q <= zero1_q;
    far2_q  <= far1_q;
    f2s_q   <= f1_q;
    f2_2_q  <= f2_1_q;
    f3_2_q  <= f2_1_q * f1_q;

    zero3_q <= zero2_q;
    num_q   <= num_d;

    zero4_q <= zero3_q;
    neg4_q  <= num_q[63];
    mag4_q  <= nabs[50:32];

    zero5_q <= zero4_q;
    neg5_q  <= neg4_q;
    mag5_q  <= mag4_q;
    est5_q  <= est_prod[35:18];

    if (zero5_q) begin
      weight_o <= '0;
    end else begin
      weight_o <= neg5_q ? weight_t'(-quo) : weight_t'(quo);
    end
  end

endmodule

`default_nettype wire

// File: src/catmull_rom_bicubic_upscale.sv
// ----------------------------------------------------------------------------
// catmull_rom_bicubic_upscale: integer-factor Catmull-Rom bicubic upscaler
// Stores a source grid and interpolates destination pixels on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries write and compute items.
//   A write item stores one sample and gives no result; the input stays ready.
//   A compute item gives one result on the output channel
//   (out_valid_o/out_ready_i). It first runs the serial position dividers
//   (27 steps, both axes side by side), then runs eight weights through the
//   kernel pipeline, then does 16 multiply-accumulates against the grid
//   RAM with pipeline fill, and last loads the output register.
//   The input is not ready while a compute item is at work, so a new item
//   is taken only once the last compute item is done; a write item is taken
//   every cycle while no compute item is at work.
//   The result sits in an output register; a new item is accepted while it
//   waits. When the receiver stalls, a finished result holds until the
//   register is free and the input stays not ready meanwhile.
//   Configuration writes take effect in the following cycle. Reset sets the
//   registers to their defaults and clears the handshake state; grid contents
//   are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_bicubic_upscale #(
  parameter int MAX_WIDTH   = crbu_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT  = crbu_pkg::DefMaxHeight,
  parameter int SAMPLE_BITS = crbu_pkg::DefSampleBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [crbu_pkg::CfgAddrBits-1:0]   cfg_addr_i,
  input  wire logic [crbu_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               opcode_i,
  input  wire logic [crbu_pkg::SrcIdxBits-1:0]    source_column_i,
  input  wire logic [crbu_pkg::SrcIdxBits-1:0]    source_row_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_value_i,
  input  wire logic [crbu_pkg::DestIdxBits-1:0]   dest_column_i,
  input  wire logic [crbu_pkg::DestIdxBits-1:0]   dest_row_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [crbu_pkg::PixelBits-1:0]   pixel_value_o,
  output logic                                    stopped_early_o
);

  import crbu_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int TermW = SAMPLE_BITS + 4;
  localparam int AccW  = (SAMPLE_BITS + 8 > PixelBits + 1) ? SAMPLE_BITS + 8 : PixelBits + 1;
  localparam int XW    = 13;

  localparam logic signed [AccW-1:0] OutMax =
    $signed({{(AccW-PixelBits+1){1'b0}}, {(PixelBits-1){1'b1}}});
  localparam logic signed [AccW-1:0] OutMin =
    $signed({{(AccW-PixelBits+1){1'b1}}, {(PixelBits-1){1'b0}}});

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_WGT, ST_MAC, ST_FIN} state_e;

  state_e state_q;

  // configuration
  logic [DimBits-1:0]    src_w_q, src_h_q;
  logic [FactorBits-1:0] factor_q;
  logic [LimitBits-1:0]  limit_q;
  logic signed [XW-1:0]  wm1, hm1;
  logic [FactorBits-1:0] r_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= RST_SRC_WIDTH;
      src_h_q  <= RST_SRC_HEIGHT;
      factor_q <= RST_FACTOR;
      limit_q  <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SRC_WIDTH:  src_w_q  <= cfg_data_i[DimBits-1:0];
        CFG_SRC_HEIGHT: src_h_q  <= cfg_data_i[DimBits-1:0];
        CFG_FACTOR:     factor_q <= cfg_data_i[FactorBits-1:0];
        CFG_LIMIT:      limit_q  <= cfg_data_i[LimitBits-1:0];
        default:        limit_q  <= limit_q;
      endcase
    end
  end

  always_comb begin
    if (src_w_q == '0) begin
      wm1 = '0;
    end else if (int'(src_w_q) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = $signed({{(XW-DimBits){1'b0}}, src_w_q}) - XW'(1);
    end
    if (src_h_q == '0) begin
      hm1 = '0;
    end else if (int'(src_h_q) > MAX_HEIGHT) begin
      hm1 = XW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = $signed({{(XW-DimBits){1'b0}}, src_h_q}) - XW'(1);
    end
    if (factor_q == '0) begin
      r_eff = FactorBits'(1);
    end else if (int'(factor_q) > MaxFactor) begin
      r_eff = FactorBits'(MaxFactor);
    end else begin
      r_eff = factor_q;
    end
  end

  // input handshake
  logic accept, do_compute, ram_we;
  logic [AW-1:0] waddr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign do_compute = accept && (opcode_i == OP_COMPUTE);
  assign ram_we     = accept && (opcode_i == OP_WRITE)
                      && (int'(source_column_i) < MAX_WIDTH)
                      && (int'(source_row_i) < MAX_HEIGHT);
  assign waddr      = AW'(int'(source_row_i) * MAX_WIDTH + int'(source_column_i));

  // position dividers
  logic signed [WholeBits:0] s_col, s_row;
  logic [WholeBits-1:0]      sa_col, sa_row;
  logic                      neg_col_q, neg_row_q;
  logic                      done_col, done_row;
  logic [DivNBits-1:0]       quo_col, quo_row;

  assign s_col  = $signed({1'b0, dest_column_i, 1'b0})
                  - $signed({{(WholeBits+1-FactorBits){1'b0}}, r_eff});
  assign s_row  = $signed({1'b0, dest_row_i, 1'b0})
                  - $signed({{(WholeBits+1-FactorBits){1'b0}}, r_eff});
  assign sa_col = s_col[WholeBits] ? WholeBits'(-s_col) : s_col[WholeBits-1:0];
  assign sa_row = s_row[WholeBits] ? WholeBits'(-s_row) : s_row[WholeBits-1:0];

  crbu_div #(.NB(DivNBits), .DB(DivDBits)) u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_compute),
    .dividend_i ({sa_col, 16'b0}),
    .divisor_i  ({r_eff, 1'b0}),
    .done_o     (done_col),
    .quotient_o (quo_col)
  );

  crbu_div #(.NB(DivNBits), .DB(DivDBits)) u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_compute),
    .dividend_i ({sa_row, 16'b0}),
    .divisor_i  ({r_eff, 1'b0}),
    .done_o     (done_row),
    .quotient_o (quo_row)
  );

  // negative positions lie within one step of zero: whole part is zero
  logic [WholeBits-1:0] p_whole, q_whole;
  logic signed [16:0]   a16, b16;

  assign p_whole = neg_col_q ? '0 : quo_col[DivNBits-1:16];
  assign q_whole = neg_row_q ? '0 : quo_row[DivNBits-1:16];
  assign a16     = neg_col_q ? 17'(-{1'b0, quo_col[15:0]}) : {1'b0, quo_col[15:0]};
  assign b16     = neg_row_q ? 17'(-{1'b0, quo_row[15:0]}) : {1'b0, quo_row[15:0]};

  // weight unit feed
  logic [3:0]        wk_q, wo_q;
  logic signed [2:0] wm3;
  logic              k_in_valid, k_out_valid;
  arg_t              k_arg;
  weight_t           k_weight;
  weight_t           wa_q [4];
  weight_t           wb_q [4];

  assign wm3        = $signed({1'b0, wk_q[1:0]}) - 3'sd1;
  assign k_in_valid = (state_q == ST_WGT) && !wk_q[3];
  assign k_arg      = wk_q[2]
                      ? arg_t'($signed({wm3, 16'b0}) - $signed({{2{b16[16]}}, b16}))
                      : arg_t'($signed({{2{a16[16]}}, a16}) - $signed({wm3, 16'b0}));

  crbu_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (k_in_valid),
    .arg_i       (k_arg),
    .out_valid_o (k_out_valid),
    .weight_o    (k_weight)
  );

  always_ff @(posedge clk_i) begin
    if (k_out_valid) begin
      if (wo_q[2]) begin
        wb_q[wo_q[1:0]] <= k_weight;
      end else begin
        wa_q[wo_q[1:0]] <= k_weight;
      end
    end
  end

  // multiply-accumulate over the 4x4 neighborhood, m outer, n inner
  logic [4:0]              mk_q;
  logic                    issue;
  logic signed [2:0]       mm3, nn3;
  logic signed [XW-1:0]    xs, ys, xc, yc;
  logic [AW-1:0]           raddr;
  logic [SAMPLE_BITS-1:0]  rdata;
  logic signed [35:0]      wprod;
  logic signed [19:0]      wab_q;
  logic signed [SAMPLE_BITS+19:0] tprod;
  logic signed [TermW-1:0] term_q;
  logic                    v0_q, v1_q, last0_q, last1_q;
  logic signed [AccW-1:0]  acc_q, acc_new;
  logic                    stop_q;
  logic                    out_load;

  assign issue = (state_q == ST_MAC) && !mk_q[4];
  assign mm3   = $signed({1'b0, mk_q[3:2]}) - 3'sd1;
  assign nn3   = $signed({1'b0, mk_q[1:0]}) - 3'sd1;
  assign xs    = $signed({{(XW-WholeBits){1'b0}}, p_whole}) + XW'(mm3);
  assign ys    = $signed({{(XW-WholeBits){1'b0}}, q_whole}) + XW'(nn3);

  always_comb begin
    if (xs < 0) begin
      xc = '0;
    end else if (xs > wm1) begin
      xc = wm1;
    end else begin
      xc = xs;
    end
    if (ys < 0) begin
      yc = '0;
    end else if (ys > hm1) begin
      yc = hm1;
    end else begin
      yc = ys;
    end
  end

  assign raddr = AW'(int'(yc) * MAX_WIDTH + int'(xc));

  crbu_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(Depth)) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (sample_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign wprod   = wa_q[mk_q[3:2]] * wb_q[mk_q[1:0]];
  assign tprod   = wab_q * $signed(rdata);
  assign acc_new = acc_q + AccW'(term_q);

  always_ff @(posedge clk_i) begin
    wab_q  <= wprod[35:16];
    term_q <= tprod[SAMPLE_BITS+19:16];
  end

  // load the output register once the previous result has left
  assign out_load = (state_q == ST_FIN) && (!out_valid_o || out_ready_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      neg_col_q       <= 1'b0;
      neg_row_q       <= 1'b0;
      wk_q            <= '0;
      wo_q            <= '0;
      mk_q            <= '0;
      v0_q            <= 1'b0;
      v1_q            <= 1'b0;
      last0_q         <= 1'b0;
      last1_q         <= 1'b0;
      acc_q           <= '0;
      stop_q          <= 1'b0;
      out_valid_o     <= 1'b0;
      stopped_early_o <= 1'b0;
    end else begin
      v0_q    <= issue;
      last0_q <= issue && (mk_q[3:0] == 4'hF);
      v1_q    <= v0_q;
      last1_q <= last0_q;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (v1_q && !stop_q) begin
        acc_q <= acc_new;
        if (acc_new > $signed({{(AccW-LimitBits){1'b0}}, limit_q})) begin
          stop_q <= 1'b1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (do_compute) begin
            neg_col_q <= s_col[WholeBits];
            neg_row_q <= s_row[WholeBits];
            acc_q     <= '0;
            stop_q    <= 1'b0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (done_col) begin
            wk_q    <= '0;
            wo_q    <= '0;
            state_q <= ST_WGT;
          end
        end
        ST_WGT: begin
          if (k_in_valid) begin
            wk_q <= wk_q + 1'b1;
          end
          if (k_out_valid) begin
            wo_q <= wo_q + 1'b1;
            if (wo_q == 4'd7) begin
              mk_q    <= '0;
              state_q <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          if (issue) begin
            mk_q <= mk_q + 1'b1;
          end
          if (v1_q && last1_q) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_load) begin
            stopped_early_o <= stop_q;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (acc_q > OutMax) begin
        pixel_value_o <= OutMax[PixelBits-1:0];
      end else if (acc_q < OutMin) begin
        pixel_value_o <= OutMin[PixelBits-1:0];
      end else begin
        pixel_value_o <= acc_q[PixelBits-1:0];
      end
    end
  end

  // assertions
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_col == done_row)
    else $error("position dividers out of step");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !ram_we)
    else $error("grid written during a compute item");

  a_stop_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stopped_early_o) |->
      (pixel_value_o >= $signed({1'b0, limit_q})))
    else $error("early stop flagged below the abort limit");

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the Catmull-Rom bicubic upscaler
// Loads source samples, runs compute items under several register settings,
// predicts each pixel in the testbench and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import crbu_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 120;
  localparam int GridMax    = DefMaxWidth * DefMaxHeight;
  localparam int PhaseItems = 130;

  typedef struct {
    logic                        op;
    logic [SrcIdxBits-1:0]       scol;
    logic [SrcIdxBits-1:0]       srow;
    logic signed [31:0]          samp;
    logic [DestIdxBits-1:0]      dcol;
    logic [DestIdxBits-1:0]      drow;
  } req_t;

  typedef struct {
    logic signed [PixelBits-1:0] pix;
    logic                        stop;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgAddrBits-1:0] cfg_addr = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_WRITE;
  logic [SrcIdxBits-1:0] scol = '0, srow = '0;
  logic signed [31:0] samp = '0;
  logic [DestIdxBits-1:0] dcol = '0, drow = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PixelBits-1:0] pixel_value;
  logic stopped_early;

  catmull_rom_bicubic_upscale dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(op), .source_column_i(scol), .source_row_i(srow),
    .sample_value_i(samp), .dest_column_i(dcol), .dest_row_i(drow),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pixel_value_o(pixel_value), .stopped_early_o(stopped_early)
  );

  // predictor state
  longint grid[GridMax];
  bit     gen_written[GridMax];
  logic [DimBits-1:0]    reg_width  = RST_SRC_WIDTH;
  logic [DimBits-1:0]    reg_height = RST_SRC_HEIGHT;
  logic [FactorBits-1:0] reg_factor = RST_FACTOR;
  logic [LimitBits-1:0]  reg_limit  = RST_LIMIT;

  req_t   pend_items[$];
  pixel_t pixel_expect[$];
  req_t   cur;
  int     errors = 0, cycles = 0, n_writes = 0, n_computes = 0, n_stops = 0;
  bit     no_idle = 1'b0, hold_go = 1'b0, hold_done = 1'b0;
  int     hold_cnt = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint eff(longint v, longint maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint cr_weight(longint t);
    longint f, f2, f3, num;
    f = t < 0 ? -t : t;
    f2 = f * f;
    f3 = f2 * f;
    if (f < 65536)
      num = 9 * f3 - 15 * f2 * 65536 + 6 * (64'sd1 << 48);
    else if (f < 2 * 65536)
      num = -3 * f3 + 15 * f2 * 65536 - 24 * f * (64'sd1 << 32) + 12 * (64'sd1 << 48);
    else
      return 0;
    return num / (6 * (64'sd1 << 32));
  endfunction

  function automatic void src_position(longint idx, longint r, output longint whole,
                                       output longint frac);
    longint s, d;
    s = 2 * idx - r;
    d = 2 * r;
    whole = s / d;
    frac = ((s - whole * d) * 65536) / d;
  endfunction

  function automatic int grid_index(longint x, longint y);
    longint w, h;
    w = eff(reg_width, DefMaxWidth);
    h = eff(reg_height, DefMaxHeight);
    if (x < 0) x = 0;
    if (x > w - 1) x = w - 1;
    if (y < 0) y = 0;
    if (y > h - 1) y = h - 1;
    return int'(y * DefMaxWidth + x);
  endfunction

  function automatic pixel_t interpolate(req_t it);
    longint r, p, a16, q, b16, acc, wa, wab;
    bit     stop;
    pixel_t res;
    r = eff(reg_factor, MaxFactor);
    src_position(longint'(it.dcol), r, p, a16);
    src_position(longint'(it.drow), r, q, b16);
    acc = 0;
    stop = 0;
    for (int m = -1; m < 3 && !stop; m++) begin
      wa = cr_weight(a16 - m * 65536);
      for (int n = -1; n < 3 && !stop; n++) begin
        wab = (wa * cr_weight(n * 65536 - b16)) >>> 16;
        acc += (wab * grid[grid_index(p + m, q + n)]) >>> 16;
        if (acc > longint'(reg_limit)) stop = 1;
      end
    end
    if (acc > 64'sd549755813887) acc = 64'sd549755813887;
    if (acc < -64'sd549755813888) acc = -64'sd549755813888;
    res.pix = acc[PixelBits-1:0];
    res.stop = stop;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("catmull_rom_bicubic_upscale verification failed");
      $finish;
    end
  end

  // driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        if (cur.op == OP_WRITE) begin
          grid[int'(cur.srow) * DefMaxWidth + int'(cur.scol)] = longint'(cur.samp);
          n_writes++;
        end else begin
          pixel_expect.push_back(interpolate(cur));
          n_computes++;
        end
      end
      if (!in_valid || in_ready) begin
        if (pend_items.size() > 0 && (no_idle || $urandom_range(99) >= 36)) begin
          cur = pend_items.pop_front();
          op <= cur.op; scol <= cur.scol; srow <= cur.srow;
          samp <= cur.samp; dcol <= cur.dcol; drow <= cur.drow;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // count the long receiver hold-off
  always @(posedge clk_i) begin
    if (rst_ni && hold_go && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end
  end

  // monitor: check results in order, stall at random, one long hold-off
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pixel_expect.size() == 0) begin
          report("unexpected result", pixel_value, 0);
        end else begin
          want = pixel_expect.pop_front();
          if (pixel_value !== want.pix) report("pixel_value", pixel_value, want.pix);
          if (stopped_early !== want.stop) report("stopped_early", stopped_early, want.stop);
          if (want.stop) n_stops++;
        end
      end
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= 36;
      end
    end
  end

  task automatic cfg_write(logic [CfgAddrBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  reg_width  = val[DimBits-1:0];
      CFG_SRC_HEIGHT: reg_height = val[DimBits-1:0];
      CFG_FACTOR:     reg_factor = val[FactorBits-1:0];
      default:        reg_limit  = val[LimitBits-1:0];
    endcase
  endtask

  task automatic add_write(int c, int r, logic signed [31:0] v);
    req_t it;
    it = '{OP_WRITE, c[SrcIdxBits-1:0], r[SrcIdxBits-1:0], v,
           DestIdxBits'($urandom), DestIdxBits'($urandom)};
    pend_items.push_back(it);
    gen_written[r * DefMaxWidth + c] = 1'b1;
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  // fill any unwritten neighbor first so no read hits an empty grid entry
  task automatic add_compute(int i, int j);
    longint p, a, q, b, r;
    int k;
    req_t it;
    r = eff(reg_factor, MaxFactor);
    src_position(i, r, p, a);
    src_position(j, r, q, b);
    for (int m = -1; m < 3; m++)
      for (int n = -1; n < 3; n++) begin
        k = grid_index(p + m, q + n);
        if (!gen_written[k]) add_write(k % DefMaxWidth, k / DefMaxWidth, rand_sample());
      end
    it = '{OP_COMPUTE, SrcIdxBits'($urandom), SrcIdxBits'($urandom), $urandom,
           i[DestIdxBits-1:0], j[DestIdxBits-1:0]};
    pend_items.push_back(it);
  endtask

  task automatic drain();
    while (pend_items.size() > 0 || in_valid || pixel_expect.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    int w_set[6] = '{64, 1, 0, 127, 5, 64};
    int h_set[6] = '{64, 1, 0, 127, 3, 37};
    int f_set[6] = '{10, 1, 0, 31, 16, 3};
    longint l_set[6] = '{64'sd4096000000, 64'sd0, 64'sd100000, 64'sh7f_ffff_ffff,
                         64'sh7f_ffff_ffff, 64'sd50000000};
    int span;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, corners and sample extremes
    add_write(0, 0, 32'sh7fffffff);
    add_write(63, 63, 32'sh80000000);
    add_write(1, 0, 32'sh80000000);
    add_write(0, 1, 32'sh7fffffff);
    add_compute(0, 0);
    add_compute(5, 5);
    add_compute(1023, 1023);
    add_compute(1023, 0);
    add_compute(0, 1023);
    add_compute(639, 639);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_SRC_WIDTH, CfgDataBits'(w_set[ph]));
      cfg_write(CFG_SRC_HEIGHT, CfgDataBits'(h_set[ph]));
      cfg_write(CFG_FACTOR, CfgDataBits'(f_set[ph]));
      cfg_write(CFG_LIMIT, ph == 5 ? CfgDataBits'({$urandom, $urandom})
                                   : CfgDataBits'(l_set[ph]));
      no_idle = (ph == 2);
      if (ph == 3) hold_go = 1'b1;
      span = int'(eff(reg_width, DefMaxWidth) * eff(reg_factor, MaxFactor)) + 20;
      // neighbor fills count toward the phase budget
      while (pend_items.size() < PhaseItems) begin
        if ($urandom_range(99) < 55) begin
          add_write($urandom_range(63), $urandom_range(63), rand_sample());
        end else if ($urandom_range(4) == 0) begin
          add_compute($urandom_range(1023), $urandom_range(1023));
        end else begin
          add_compute($urandom_range(span > 1023 ? 1023 : span),
                      $urandom_range(span > 1023 ? 1023 : span));
        end
      end
      drain();
    end

    $display("covered %0d sample writes and %0d pixels (%0d stopped early)",
             n_writes, n_computes, n_stops);
    $display("over six register settings with random stalls and one long hold-off");
    if (errors == 0) begin
      $display("catmull_rom_bicubic_upscale verification clean");
    end else begin
      $display("catmull_rom_bicubic_upscale verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
